[src/ipv4fp_pkg.sv]
// ----------------------------------------------------------------------------
// ipv4fp_pkg
// Constants, control word types and the sequencer program of the IPv4
// fragment planner.
// ----------------------------------------------------------------------------
package ipv4fp_pkg;

    // Protocol constants
    localparam logic [15:0] HDR_BYTES = 16'd20;
    localparam logic [15:0] MIN_MTU   = 16'd1084;
    localparam logic [15:0] MIN_FRAG  = 16'd1024;
    localparam logic [15:0] MTU_RESET = 16'd1500;
    localparam int          MF_POS    = 13;
    localparam int          OFS_SHIFT = 3;
    localparam logic [5:0]  MAX_FULL  = 6'd63;   // full fragments before the final one

    // Program counter
    typedef logic [2:0] t_step;

    localparam t_step STEP_IDLE = 3'd0;
    localparam t_step STEP_SIZE = 3'd1;
    localparam t_step STEP_TEST = 3'd2;
    localparam t_step STEP_FULL = 3'd3;
    localparam t_step STEP_LAST = 3'd4;
    localparam t_step STEP_PASS = 3'd5;

    // What a step sends to the output register
    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_FULL,
        EMIT_LAST,
        EMIT_PASS
    } t_emit;

    // Jump condition
    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_ACCEPT,
        COND_PASS,
        COND_DONE,
        COND_SENT
    } t_cond;

    // Where to go when the condition is false
    typedef enum logic {
        ELSE_STAY,
        ELSE_NEXT
    } t_else;

    typedef struct packed {
        logic  in_rdy;    // take a request this step
        logic  ld_size;   // compute fragment size
        t_emit emit;
        t_cond cond;
        t_else els;
        t_step tgt;
    } t_ctrl;

    // Microcode ROM
    function automatic t_ctrl ctrl_rom(input t_step step);
        t_ctrl c;
        c = '{in_rdy: 1'b0, ld_size: 1'b0, emit: EMIT_NONE, cond: COND_ALWAYS,
              els: ELSE_STAY, tgt: STEP_IDLE};
        case (step)
            STEP_IDLE: begin
                c.in_rdy = 1'b1;
                c.cond   = COND_ACCEPT;
                c.tgt    = STEP_SIZE;
            end
            STEP_SIZE: begin
                c.ld_size = 1'b1;
                c.tgt     = STEP_TEST;
            end
            STEP_TEST: begin
                c.cond = COND_PASS;
                c.els  = ELSE_NEXT;
                c.tgt  = STEP_PASS;
            end
            STEP_FULL: begin
                c.emit = EMIT_FULL;
                c.cond = COND_DONE;
                c.tgt  = STEP_LAST;
            end
            STEP_LAST: begin
                c.emit = EMIT_LAST;
                c.cond = COND_SENT;
                c.tgt  = STEP_IDLE;
            end
            STEP_PASS: begin
                c.emit = EMIT_PASS;
                c.cond = COND_SENT;
                c.tgt  = STEP_IDLE;
            end
            default: begin
                c.tgt = STEP_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

[src/ipv4fp_if.sv]
// ----------------------------------------------------------------------------
// ipv4fp interfaces
// Valid/ready channels for configuration, packet descriptors and fragment
// descriptors.
// ----------------------------------------------------------------------------
interface ipv4fp_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ipv4fp_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] payload_length;
    logic [5:0]  options_length;
    logic [15:0] flags_in;

    modport source (output valid, output payload_length, output options_length,
                    output flags_in, input ready);
    modport sink   (input valid, input payload_length, input options_length,
                    input flags_in, output ready);
endinterface

interface ipv4fp_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] fragment_offset;
    logic [15:0] fragment_length;
    logic [15:0] flags_out;
    logic        carries_options;
    logic        last;

    modport source (output valid, output fragment_offset, output fragment_length,
                    output flags_out, output carries_options, output last,
                    input ready);
    modport sink   (input valid, input fragment_offset, input fragment_length,
                    input flags_out, input carries_options, input last,
                    output ready);
endinterface

[src/ipv4_fragment_planner.sv]
// ----------------------------------------------------------------------------
// ipv4_fragment_planner
// Splits an IPv4 packet descriptor into fragment descriptors under control
// of a small microcode program.
// ----------------------------------------------------------------------------
// Sequence: the idle step takes the request, the size step loads the fragment size,
//   the test step picks pass-through or fragmenting, then the emit steps run;
//   one fragment per cycle from the emit step while the output is taken.
// Output register decouples the sides; the next request is taken while the
//   final fragment still waits downstream.
// Reset (synchronous, active low): sequencer to idle, output empty, MTU 1500.
module ipv4_fragment_planner (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ipv4fp_cfg_if.sink    i_cfg,
    ipv4fp_in_if.sink     i_in,
    ipv4fp_out_if.source  o_out
);

    // Sequencer and datapath registers
    ipv4fp_pkg::t_step r_pc;
    ipv4fp_pkg::t_step n_pc;
    ipv4fp_pkg::t_ctrl w_ctrl;

    logic [15:0] r_mtu;
    logic [15:0] r_plen;
    logic [5:0]  r_olen;
    logic [15:0] r_fin;
    logic [15:0] r_size;
    logic [15:0] r_ofs;
    logic [15:0] r_rest;
    logic [5:0]  r_k;

    logic        r_out_valid;
    logic [15:0] r_o_ofs;
    logic [15:0] r_o_len;
    logic [15:0] r_o_flags;
    logic        r_o_opt;
    logic        r_o_last;

    logic        w_accept;
    logic        w_out_free;
    logic        w_pass;
    logic        w_done;
    logic        w_cond;
    logic        w_fire;
    logic        w_has_opt;
    logic [15:0] w_mtu;
    logic [15:0] w_diff;
    logic [15:0] w_round;
    logic [15:0] n_size;

    // Current control word
    assign w_ctrl = ipv4fp_pkg::ctrl_rom(r_pc);

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = w_ctrl.in_rdy;
    assign w_accept    = i_in.valid && w_ctrl.in_rdy;
    assign w_out_free  = !r_out_valid || o_out.ready;

    // Fragment size: clamped MTU less header and options, 8-byte aligned
    assign w_mtu   = (r_mtu < ipv4fp_pkg::MIN_MTU) ? ipv4fp_pkg::MIN_MTU : r_mtu;
    assign w_diff  = w_mtu - ipv4fp_pkg::HDR_BYTES - {10'd0, r_olen};
    assign w_round = {w_diff[15:ipv4fp_pkg::OFS_SHIFT], 3'b000};
    assign n_size  = (w_round < ipv4fp_pkg::MIN_FRAG) ? ipv4fp_pkg::MIN_FRAG : w_round;

    // Status flags for the jump conditions
    assign w_has_opt = (r_olen != 6'd0);
    assign w_pass    = r_fin[ipv4fp_pkg::MF_POS] || (r_plen == 16'd0) || (r_plen <= r_size);
    assign w_done    = !((r_rest > r_size) && (r_k < ipv4fp_pkg::MAX_FULL));

    always_comb begin
        case (w_ctrl.cond)
            ipv4fp_pkg::COND_ALWAYS: w_cond = 1'b1;
            ipv4fp_pkg::COND_ACCEPT: w_cond = w_accept;
            ipv4fp_pkg::COND_PASS:   w_cond = w_pass;
            ipv4fp_pkg::COND_DONE:   w_cond = w_done;
            ipv4fp_pkg::COND_SENT:   w_cond = w_out_free;
            default:                 w_cond = 1'b1;
        endcase
    end

    // Emit when the output register has room; a full step emits only while more remain
    assign w_fire = (w_ctrl.emit != ipv4fp_pkg::EMIT_NONE) && w_out_free &&
                    !((w_ctrl.emit == ipv4fp_pkg::EMIT_FULL) && w_done);

    // Next step
    always_comb begin
        if (w_cond) begin
            n_pc = w_ctrl.tgt;
        end else if (w_ctrl.els == ipv4fp_pkg::ELSE_NEXT) begin
            n_pc = r_pc + 3'd1;
        end else begin
            n_pc = r_pc;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= ipv4fp_pkg::STEP_IDLE;
            r_mtu       <= ipv4fp_pkg::MTU_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (i_cfg.valid) begin
                r_mtu <= i_cfg.data;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_plen <= i_in.payload_length;
            r_olen <= i_in.options_length;
            r_fin  <= i_in.flags_in;
            r_ofs  <= 16'd0;
            r_rest <= i_in.payload_length;
            r_k    <= 6'd0;
        end
        if (w_ctrl.ld_size) begin
            r_size <= n_size;
        end
        if (w_fire) begin
            case (w_ctrl.emit)
                ipv4fp_pkg::EMIT_FULL: begin
                    r_o_ofs   <= r_ofs;
                    r_o_len   <= r_size;
                    r_o_flags <= {3'b001, r_ofs[15:ipv4fp_pkg::OFS_SHIFT]};
                    r_o_opt   <= (r_k == 6'd0) && w_has_opt;
                    r_o_last  <= 1'b0;
                    r_ofs     <= r_ofs + r_size;
                    r_rest    <= r_rest - r_size;
                    r_k       <= r_k + 6'd1;
                end
                ipv4fp_pkg::EMIT_LAST: begin
                    r_o_ofs   <= r_ofs;
                    r_o_len   <= r_rest;
                    r_o_flags <= {3'b000, r_ofs[15:ipv4fp_pkg::OFS_SHIFT]};
                    r_o_opt   <= 1'b0;
                    r_o_last  <= 1'b1;
                end
                ipv4fp_pkg::EMIT_PASS: begin
                    r_o_ofs   <= 16'd0;
                    r_o_len   <= r_plen;
                    r_o_flags <= r_fin;
                    r_o_opt   <= w_has_opt;
                    r_o_last  <= 1'b1;
                end
                default: begin
                    r_o_last  <= r_o_last;
                end
            endcase
        end
    end

    // Output channel
    assign o_out.valid           = r_out_valid;
    assign o_out.fragment_offset = r_o_ofs;
    assign o_out.fragment_length = r_o_len;
    assign o_out.flags_out       = r_o_flags;
    assign o_out.carries_options = r_o_opt;
    assign o_out.last            = r_o_last;

endmodule
